// ===== src/bss_pkg.sv =====
// shared types and constants for the backend server selector
`timescale 1ns / 1ps
`default_nettype none
package bss_pkg;

   localparam int REQ_W      = 3;
   localparam int SLOT_ID_W  = 3;
   localparam int USAGE_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int CHOSEN_W   = 3;
   localparam int SRV_CNT_W  = 4;
   localparam int POLICY_W   = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
   localparam logic [REQ_W-1:0] REQ_USAGE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SELECT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_OCC = 2'd3;

   // policy codes
   localparam logic [POLICY_W-1:0] POL_ROUND_ROBIN = 2'd0;
   localparam logic [POLICY_W-1:0] POL_LEAST_CONN  = 2'd1;
   localparam logic [POLICY_W-1:0] POL_LEAST_USAGE = 2'd2;

   typedef struct packed {
      logic want_free;   // look for an empty slot instead of an occupied one
      logic is_min;      // keep the smallest value rather than the first hit
   } scan_mode_type;

   typedef struct packed {
      logic occ_we;
      logic occ_val;
      logic conn_we;
      logic usage_we;
   } tbl_ctl_type;

endpackage
`default_nettype wire

// ===== src/bss_slot_table.sv =====
// per-slot state: occupied bits, connection counts and usage levels
`timescale 1ns / 1ps
`default_nettype none
module bss_slot_table
   import bss_pkg::*;
#(
   parameter int NUM_SLOTS = 8,
   parameter int CONN_W    = 11
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire tbl_ctl_type              wr_ctl,
   input  wire [$clog2(NUM_SLOTS)-1:0]   wr_addr,
   input  wire [CONN_W-1:0]              wr_conn,
   input  wire [USAGE_W-1:0]             wr_usage,
   input  wire [$clog2(NUM_SLOTS)-1:0]   rd_addr,
   output logic [CONN_W-1:0]             rd_conn,
   output logic [USAGE_W-1:0]            rd_usage,
   output logic [NUM_SLOTS-1:0]          occ_vec
);

   logic [NUM_SLOTS-1:0] occ_ff;
   logic [CONN_W-1:0]    conn_ff  [NUM_SLOTS];
   logic [USAGE_W-1:0]   usage_ff [NUM_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            conn_ff[i]  <= '0;
            usage_ff[i] <= '0;
         end
      end else begin
         if (wr_ctl.occ_we) begin
            occ_ff[wr_addr] <= wr_ctl.occ_val;
         end
         if (wr_ctl.conn_we) begin
            conn_ff[wr_addr] <= wr_conn;
         end
         if (wr_ctl.usage_we) begin
            usage_ff[wr_addr] <= wr_usage;
         end
      end
   end

   assign rd_conn  = conn_ff[rd_addr];
   assign rd_usage = usage_ff[rd_addr];
   assign occ_vec  = occ_ff;

endmodule
`default_nettype wire

// ===== src/bss_scan_unit.sv =====
// shared compare unit that walks the slots one per cycle
`timescale 1ns / 1ps
`default_nettype none
module bss_scan_unit
   import bss_pkg::*;
#(
   parameter int NUM_SLOTS = 8,
   parameter int VAL_W     = 11
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                clear,
   input  wire scan_mode_type                 clear_mode,
   input  wire [$clog2(NUM_SLOTS)-1:0]        clear_start,
   input  wire                                step,
   input  wire                                occ_bit,
   input  wire [VAL_W-1:0]                    val,
   output logic [$clog2(NUM_SLOTS)-1:0]       idx,
   output logic                               last,
   output logic                               found,
   output logic [$clog2(NUM_SLOTS)-1:0]       best_idx,
   output logic [$clog2(NUM_SLOTS+1)-1:0]     occ_count
);

   localparam int IW   = $clog2(NUM_SLOTS);
   localparam int CNTW = $clog2(NUM_SLOTS + 1);

   scan_mode_type   mode_ff, mode_in;
   logic [IW-1:0]   start_ff, start_in;
   logic [IW-1:0]   k_ff, k_in;
   logic            found_ff, found_in;
   logic [IW-1:0]   best_ff, best_in;
   logic [VAL_W-1:0] best_val_ff, best_val_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [IW:0]     sum;
   logic            cand;
   logic            take;

   always_comb begin
      // wrap of start plus offset, both below the slot count
      sum  = {1'b0, start_ff} + {1'b0, k_ff};
      idx  = (sum >= (IW+1)'(NUM_SLOTS)) ? IW'(sum - (IW+1)'(NUM_SLOTS)) : IW'(sum);
      last = (k_ff == IW'(NUM_SLOTS - 1));
      cand = mode_ff.want_free ? !occ_bit : occ_bit;
      take = cand && (!found_ff || (mode_ff.is_min && (val < best_val_ff)));

      mode_in     = mode_ff;
      start_in    = start_ff;
      k_in        = k_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      count_in    = count_ff;
      if (clear) begin
         mode_in  = clear_mode;
         start_in = clear_start;
         k_in     = '0;
         found_in = 1'b0;
         count_in = '0;
      end else if (step) begin
         k_in     = k_ff + IW'(1);
         count_in = count_ff + CNTW'(occ_bit);
         if (take) begin
            found_in    = 1'b1;
            best_in     = idx;
            best_val_in = val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= '0;
         found_ff <= 1'b0;
         count_ff <= '0;
         mode_ff  <= '0;
         start_ff <= '0;
      end else begin
         k_ff     <= k_in;
         found_ff <= found_in;
         count_ff <= count_in;
         mode_ff  <= mode_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
   end

   assign found     = found_ff;
   assign best_idx  = best_ff;
   assign occ_count = count_ff;

endmodule
`default_nettype wire

// ===== src/backend_server_selector_core.sv =====
// top level of the backend server selector: sequencer, policy register, result register
//
// usage:
//   req_* carries one event item (add, remove, usage report, select, close).
//   an item is taken when req_valid is high and req_stall is low.
//   rsp_* returns exactly one result item per event: chosen slot, status and
//   the number of occupied slots after the event.
//   csr_policy is written through csr_valid/csr_ready while the block is idle
//   and no item is offered:
//   0 round robin, 1 least connections, 2 least usage, 3 acts as round robin.
// sequence:
//   after an item is taken, one shared compare unit walks all NUM_SLOTS slots,
//   one slot per cycle, then the update state writes the slot table and loads the
//   result register, which raises rsp_valid. the next item can be taken the
//   cycle after the result is taken.
// reset: synchronous, clears the slot table, round robin pointer and policy.
// a stalled result holds in the output register; req_stall stays high until
// that result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module backend_server_selector_core
   import bss_pkg::*;
#(
   parameter int NUM_SLOTS = 8,
   parameter int MAX_CONN  = 1024
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire [REQ_W-1:0]          req_type,
   input  wire [SLOT_ID_W-1:0]      req_slot_id,
   input  wire [USAGE_W-1:0]        req_usage_value,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [CHOSEN_W-1:0]      rsp_chosen_slot,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SRV_CNT_W-1:0]     rsp_server_count,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [POLICY_W-1:0]       csr_policy
);

   localparam int IW     = $clog2(NUM_SLOTS);
   localparam int CNTW   = $clog2(NUM_SLOTS + 1);
   localparam int CONN_W = $clog2(MAX_CONN + 1);
   localparam int VAL_W  = (CONN_W > USAGE_W) ? CONN_W : USAGE_W;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_UPDATE = 4'b0100,
      S_RESP   = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [POLICY_W-1:0]    policy_ff, policy_in;
   logic [IW-1:0]          rr_ptr_ff, rr_ptr_in;
   logic                   rr_valid_ff, rr_valid_in;
   logic [REQ_W-1:0]       req_type_ff, req_type_in;
   logic [SLOT_ID_W-1:0]   slot_ff, slot_in;
   logic [USAGE_W-1:0]     usage_ff, usage_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHOSEN_W-1:0]    rsp_chosen_ff, rsp_chosen_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SRV_CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                   accept;
   logic                   policy_min;
   scan_mode_type          scan_mode;
   logic [IW-1:0]          scan_start;
   logic [IW-1:0]          scan_idx;
   logic                   scan_last;
   logic                   scan_found;
   logic [IW-1:0]          scan_best;
   logic [CNTW-1:0]        scan_count;
   logic [VAL_W-1:0]       scan_val;

   tbl_ctl_type            tbl_ctl;
   logic [IW-1:0]          wr_addr;
   logic [CONN_W-1:0]      wr_conn;
   logic [USAGE_W-1:0]     wr_usage;
   logic [IW-1:0]          rd_addr;
   logic [CONN_W-1:0]      rd_conn;
   logic [USAGE_W-1:0]     rd_usage;
   logic [NUM_SLOTS-1:0]   occ_vec;

   logic [IW-1:0]          slot_idx;
   logic                   target_ok;
   logic [CNTW-1:0]        cnt_next;
   logic [CHOSEN_W-1:0]    chosen;
   logic [STATUS_W-1:0]    status;
   logic                   rr_set;

   assign accept     = (state_ff == S_IDLE) && req_valid;
   assign req_stall  = (state_ff != S_IDLE);
   // policy never changes on the edge that takes an item
   assign csr_ready  = (state_ff == S_IDLE) && !req_valid;
   assign policy_min = (policy_ff == POL_LEAST_CONN) || (policy_ff == POL_LEAST_USAGE);

   // scan setup for the incoming item
   always_comb begin
      scan_mode.want_free = (req_type == REQ_ADD);
      scan_mode.is_min    = (req_type == REQ_SELECT) && policy_min;
      scan_start          = '0;
      if ((req_type == REQ_SELECT) && !policy_min && rr_valid_ff) begin
         scan_start = (rr_ptr_ff == IW'(NUM_SLOTS - 1)) ? '0 : rr_ptr_ff + IW'(1);
      end
   end

   assign scan_val = (policy_ff == POL_LEAST_CONN) ? VAL_W'(rd_conn) : VAL_W'(rd_usage);

   bss_scan_unit #(
      .NUM_SLOTS (NUM_SLOTS),
      .VAL_W     (VAL_W)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (accept),
      .clear_mode  (scan_mode),
      .clear_start (scan_start),
      .step        (state_ff == S_SCAN),
      .occ_bit     (occ_vec[scan_idx]),
      .val         (scan_val),
      .idx         (scan_idx),
      .last        (scan_last),
      .found       (scan_found),
      .best_idx    (scan_best),
      .occ_count   (scan_count)
   );

   bss_slot_table #(
      .NUM_SLOTS (NUM_SLOTS),
      .CONN_W    (CONN_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_ctl   (tbl_ctl),
      .wr_addr  (wr_addr),
      .wr_conn  (wr_conn),
      .wr_usage (wr_usage),
      .rd_addr  (rd_addr),
      .rd_conn  (rd_conn),
      .rd_usage (rd_usage),
      .occ_vec  (occ_vec)
   );

   assign slot_idx  = IW'(slot_ff);
   assign target_ok = (32'(slot_ff) < NUM_SLOTS) && occ_vec[slot_idx];

   // read address: scan walk, then the slot the update works on
   always_comb begin
      if (state_ff == S_SCAN) begin
         rd_addr = scan_idx;
      end else if ((req_type_ff == REQ_ADD) || (req_type_ff == REQ_SELECT)) begin
         rd_addr = scan_best;
      end else begin
         rd_addr = slot_idx;
      end
   end

   // event update, applied to the table only in the update cycle
   always_comb begin
      tbl_ctl  = '0;
      wr_addr  = slot_idx;
      wr_conn  = '0;
      wr_usage = '0;
      chosen   = slot_ff;
      status   = ST_OK;
      cnt_next = scan_count;
      rr_set   = 1'b0;
      case (req_type_ff)
         REQ_ADD: begin
            if (scan_found) begin
               tbl_ctl.occ_we  = 1'b1;
               tbl_ctl.occ_val = 1'b1;
               tbl_ctl.conn_we = 1'b1;
               wr_addr         = scan_best;
               chosen          = CHOSEN_W'(scan_best);
               cnt_next        = scan_count + CNTW'(1);
            end else begin
               status = ST_FULL;
               chosen = '0;
            end
         end
         REQ_REMOVE: begin
            if (target_ok) begin
               tbl_ctl.occ_we   = 1'b1;
               tbl_ctl.conn_we  = 1'b1;
               tbl_ctl.usage_we = 1'b1;
               cnt_next         = scan_count - CNTW'(1);
            end else begin
               status = ST_NOT_OCC;
            end
         end
         REQ_USAGE: begin
            if (target_ok) begin
               tbl_ctl.usage_we = 1'b1;
               wr_usage         = usage_ff;
            end else begin
               status = ST_NOT_OCC;
            end
         end
         REQ_SELECT: begin
            if (scan_found) begin
               tbl_ctl.conn_we = 1'b1;
               wr_addr         = scan_best;
               // saturate at the connection limit
               wr_conn = (32'(rd_conn) < MAX_CONN) ? rd_conn + CONN_W'(1) : rd_conn;
               chosen  = CHOSEN_W'(scan_best);
               rr_set  = !policy_min;
            end else begin
               status = ST_NONE;
               chosen = '0;
            end
         end
         REQ_CLOSE: begin
            if (target_ok) begin
               tbl_ctl.conn_we = 1'b1;
               wr_conn = (rd_conn != '0) ? rd_conn - CONN_W'(1) : rd_conn;
            end else begin
               status = ST_NOT_OCC;
            end
         end
         default: begin
         end
      endcase
      if (state_ff != S_UPDATE) begin
         tbl_ctl = '0;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      policy_in     = policy_ff;
      rr_ptr_in     = rr_ptr_ff;
      rr_valid_in   = rr_valid_ff;
      req_type_in   = req_type_ff;
      slot_in       = slot_ff;
      usage_in      = usage_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (csr_valid && csr_ready) begin
         policy_in = csr_policy;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_type_in = req_type;
               slot_in     = req_slot_id;
               usage_in    = req_usage_value;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_last) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            rsp_valid_in  = 1'b1;
            rsp_chosen_in = chosen;
            rsp_status_in = status;
            rsp_count_in  = SRV_CNT_W'(cnt_next);
            if (rr_set) begin
               rr_ptr_in   = scan_best;
               rr_valid_in = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
            state_in     = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POL_ROUND_ROBIN;
         rr_ptr_ff    <= '0;
         rr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         rr_ptr_ff    <= rr_ptr_in;
         rr_valid_ff  <= rr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      slot_ff       <= slot_in;
      usage_ff      <= usage_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_slot  = rsp_chosen_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_server_count = rsp_count_ff;

endmodule
`default_nettype wire
